@@ rtl/core/sha1bsh_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 byte stream hasher.
// No dependencies; used by every module in rtl/core.
package sha1bsh_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int ODEPTH = 8;
  localparam int OAW    = $clog2(ODEPTH);

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] BLK_LAST   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [1:0] {
    K_BYTE,
    K_BYTE_END,
    K_END
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    case (t) inside
      [7'd0:7'd19]:  k = 32'h5a827999;
      [7'd20:7'd39]: k = 32'h6ed9eba1;
      [7'd40:7'd59]: k = 32'h8f1bbcdc;
      default:       k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (t) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/sha1bsh_front.sv @@
// Front end: takes items, drops idle ones, classifies the rest into commands.
// Holds the short command queue to the back end. Uses sha1bsh_pkg.
module sha1bsh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_message,
  output logic                cmd_valid,
  output sha1bsh_pkg::cmd_t   cmd,
  input  logic                cmd_pop
);

  sha1bsh_pkg::cmd_t                 mem [sha1bsh_pkg::QDEPTH];
  logic [sha1bsh_pkg::QAW-1:0]       wp;
  logic [sha1bsh_pkg::QAW-1:0]       rp;
  logic [sha1bsh_pkg::QAW:0]         cnt;
  logic                              keep;
  logic                              take;
  sha1bsh_pkg::cmd_t                 incoming;

  assign full      = (cnt == (sha1bsh_pkg::QAW+1)'(sha1bsh_pkg::QDEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = mem[rp];
  assign keep      = push && !full && (byte_present || end_of_message);
  assign take      = cmd_pop && cmd_valid;

  always_comb begin
    incoming.data = data_byte;
    if (byte_present && end_of_message) begin
      incoming.kind = sha1bsh_pkg::K_BYTE_END;
    end else if (byte_present) begin
      incoming.kind = sha1bsh_pkg::K_BYTE;
    end else begin
      incoming.kind = sha1bsh_pkg::K_END;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      mem[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (keep) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      if (keep && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !keep) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) (cnt == '0) |=> (cnt <= (sha1bsh_pkg::QAW+1)'(1));
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("queue count underflow");

  property p_cnt_bound;
    @(posedge clk) disable iff (rst) cnt <= (sha1bsh_pkg::QAW+1)'(sha1bsh_pkg::QDEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("queue count overflow");

  property p_ptr_gap;
    @(posedge clk) disable iff (rst) (wp - rp) == cnt[sha1bsh_pkg::QAW-1:0];
  endproperty
  a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/sha1bsh_core.sv @@
// Back end: packs bytes into the block window, pads, runs the 80 rounds, emits digest words.
// Uses sha1bsh_pkg; fed by sha1bsh_front, drains into sha1bsh_outq.
module sha1bsh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  sha1bsh_pkg::cmd_t   cmd,
  output logic                cmd_pop,
  input  logic                out_space,
  output logic                res_push,
  output sha1bsh_pkg::res_t   res
);

  sha1bsh_pkg::state_t state;
  sha1bsh_pkg::state_t state_next;
  sha1bsh_pkg::state_t ret;
  sha1bsh_pkg::state_t ret_next;

  logic [31:0] hash [5];
  logic [31:0] win  [16];
  logic [31:0] va, vb, vc, vd, ve;
  logic [23:0] acc;
  logic [5:0]  pos;
  logic [60:0] count;
  logic [63:0] lenreg;
  logic        marked;
  logic [6:0]  rnd;
  logic [2:0]  widx;

  logic        push_en;
  logic [7:0]  push_byte;
  logic        fin;
  logic [31:0] wnew;
  logic [31:0] tmp;

  assign wnew = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign tmp  = {va[26:0], va[31:27]} + sha1bsh_pkg::round_f(rnd, vb, vc, vd) + ve
                + sha1bsh_pkg::round_k(rnd) + win[0];

  assign res.word = hash[widx];
  assign res.num  = widx;
  assign res.last = (widx == sha1bsh_pkg::WORD_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1bsh_pkg::ST_TAKE;
      ret   <= sha1bsh_pkg::ST_TAKE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd_pop    = 1'b0;
    push_en    = 1'b0;
    push_byte  = cmd.data;
    fin        = 1'b0;
    res_push   = 1'b0;
    case (state)
      sha1bsh_pkg::ST_TAKE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          push_en = (cmd.kind != sha1bsh_pkg::K_END);
          fin     = (cmd.kind != sha1bsh_pkg::K_BYTE);
          if (push_en && pos == sha1bsh_pkg::BLK_LAST) begin
            state_next = sha1bsh_pkg::ST_ROUND;
            ret_next   = fin ? sha1bsh_pkg::ST_PAD : sha1bsh_pkg::ST_TAKE;
          end else if (fin) begin
            state_next = sha1bsh_pkg::ST_PAD;
          end
        end
      end
      sha1bsh_pkg::ST_PAD: begin
        if (marked && pos == sha1bsh_pkg::LEN_POS) begin
          state_next = sha1bsh_pkg::ST_LEN;
        end else begin
          push_en   = 1'b1;
          push_byte = marked ? 8'h00 : sha1bsh_pkg::PAD_BYTE;
          if (pos == sha1bsh_pkg::BLK_LAST) begin
            state_next = sha1bsh_pkg::ST_ROUND;
            ret_next   = sha1bsh_pkg::ST_PAD;
          end
        end
      end
      sha1bsh_pkg::ST_LEN: begin
        push_en   = 1'b1;
        push_byte = lenreg[63:56];
        if (pos == sha1bsh_pkg::BLK_LAST) begin
          state_next = sha1bsh_pkg::ST_ROUND;
          ret_next   = sha1bsh_pkg::ST_EMIT;
        end
      end
      sha1bsh_pkg::ST_ROUND: begin
        if (rnd == sha1bsh_pkg::ROUND_LAST) begin
          state_next = sha1bsh_pkg::ST_ADD;
        end
      end
      sha1bsh_pkg::ST_ADD: begin
        state_next = ret;
      end
      sha1bsh_pkg::ST_EMIT: begin
        if (out_space) begin
          res_push = 1'b1;
          if (widx == sha1bsh_pkg::WORD_LAST) begin
            state_next = sha1bsh_pkg::ST_TAKE;
          end
        end
      end
      default: begin
        state_next = sha1bsh_pkg::ST_TAKE;
      end
    endcase
  end

  // window and round variables carry no reset
  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
      if (pos[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= {acc, push_byte};
      end
    end
    if (push_en && pos == sha1bsh_pkg::BLK_LAST) begin
      va <= hash[0];
      vb <= hash[1];
      vc <= hash[2];
      vd <= hash[3];
      ve <= hash[4];
    end
    if (state == sha1bsh_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= {wnew[30:0], wnew[31]};
      va <= tmp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
    if (fin) begin
      lenreg <= {count + 61'(push_en), 3'b000};
    end else if (state == sha1bsh_pkg::ST_LEN) begin
      lenreg <= {lenreg[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      count  <= '0;
      marked <= 1'b0;
      rnd    <= '0;
      widx   <= '0;
      for (int i = 0; i < 5; i++) begin
        hash[i] <= sha1bsh_pkg::IV[i];
      end
    end else begin
      if (push_en) begin
        pos <= pos + 1'b1;
      end
      if (fin) begin
        count  <= '0;
        marked <= 1'b0;
      end else if (state == sha1bsh_pkg::ST_TAKE && push_en) begin
        count <= count + 1'b1;
      end else if (state == sha1bsh_pkg::ST_PAD && push_en) begin
        marked <= 1'b1;
      end
      if (state == sha1bsh_pkg::ST_ROUND) begin
        rnd <= (rnd == sha1bsh_pkg::ROUND_LAST) ? '0 : rnd + 1'b1;
      end
      if (state == sha1bsh_pkg::ST_ADD) begin
        hash[0] <= hash[0] + va;
        hash[1] <= hash[1] + vb;
        hash[2] <= hash[2] + vc;
        hash[3] <= hash[3] + vd;
        hash[4] <= hash[4] + ve;
      end
      if (res_push) begin
        if (widx == sha1bsh_pkg::WORD_LAST) begin
          widx <= '0;
          for (int i = 0; i < 5; i++) begin
            hash[i] <= sha1bsh_pkg::IV[i];
          end
        end else begin
          widx <= widx + 1'b1;
        end
      end
    end
  end

  property p_round_entry;
    @(posedge clk) disable iff (rst)
      (state != sha1bsh_pkg::ST_ROUND) ##1 (state == sha1bsh_pkg::ST_ROUND) |-> (pos == '0);
  endproperty
  a_round_entry: assert property (p_round_entry) else $error("rounds started on partial block");

  property p_len_window;
    @(posedge clk) disable iff (rst) (state == sha1bsh_pkg::ST_LEN) |-> (pos >= sha1bsh_pkg::LEN_POS);
  endproperty
  a_len_window: assert property (p_len_window) else $error("length bytes out of place");

  property p_round_bound;
    @(posedge clk) disable iff (rst) (state == sha1bsh_pkg::ST_ROUND) |-> (rnd <= sha1bsh_pkg::ROUND_LAST);
  endproperty
  a_round_bound: assert property (p_round_bound) else $error("round counter overrun");

  property p_emit_wrap;
    @(posedge clk) disable iff (rst) (res_push && res.last) |=> (widx == '0 && state == sha1bsh_pkg::ST_TAKE);
  endproperty
  a_emit_wrap: assert property (p_emit_wrap) else $error("digest emission did not close");

endmodule

@@ rtl/core/sha1bsh_outq.sv @@
// Result queue holding digest words until the receiver pops them.
// Uses sha1bsh_pkg; filled by sha1bsh_core.
module sha1bsh_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_push,
  input  sha1bsh_pkg::res_t   res,
  output logic                out_space,
  output logic                empty,
  input  logic                pop,
  output sha1bsh_pkg::res_t   head
);

  sha1bsh_pkg::res_t           mem [sha1bsh_pkg::ODEPTH];
  logic [sha1bsh_pkg::OAW-1:0] wp;
  logic [sha1bsh_pkg::OAW-1:0] rp;
  logic [sha1bsh_pkg::OAW:0]   cnt;
  logic                        put;
  logic                        take;

  assign out_space = (cnt != (sha1bsh_pkg::OAW+1)'(sha1bsh_pkg::ODEPTH));
  assign empty     = (cnt == '0);
  assign head      = mem[rp];
  assign put       = res_push && out_space;
  assign take      = pop && !empty;

  always_ff @(posedge clk) begin
    if (put) begin
      mem[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (put) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      if (put && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !put) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  property p_cnt_bound;
    @(posedge clk) disable iff (rst) cnt <= (sha1bsh_pkg::OAW+1)'(sha1bsh_pkg::ODEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("result queue overflow");

  property p_no_drop;
    @(posedge clk) disable iff (rst) res_push |-> out_space;
  endproperty
  a_no_drop: assert property (p_no_drop) else $error("result pushed into full queue");

  property p_ptr_gap;
    @(posedge clk) disable iff (rst) (wp - rp) == cnt[sha1bsh_pkg::OAW-1:0];
  endproperty
  a_ptr_gap: assert property (p_ptr_gap) else $error("result pointers disagree with count");

endmodule

@@ rtl/core/sha1_byte_stream_hasher_top.sv @@
// SHA-1 byte stream hasher, top level.
// Instantiates sha1bsh_front, sha1bsh_core and sha1bsh_outq; uses sha1bsh_pkg.
//
// Input channel: an item is taken when push is high and full is low. Each item
// carries data_byte, byte_present and end_of_message. Items with neither flag
// set are taken and dropped. A four-item command queue sits in front of the
// hashing engine, so full only rises while the engine is padding, compressing or emitting.
// Result channel: while empty is low, digest_word/word_number/last_word show
// the oldest digest word; pop takes it. Five words per message, word 0 first,
// last_word set on word 4. An eight-word result queue decouples the receiver;
// a stalled receiver stops the engine only once a second digest is ready.
// Throughput: one byte per cycle into the block window while the engine takes bytes;
// each 64-byte block then holds input for the 80-round compression unit and the hash
// update. Closing a message adds padding and length bytes, one or two compressions
// and the emission of the five digest words.
// Reset (rst, synchronous, active high) empties both queues, clears the byte
// count and restores the initial hash values; the engine returns to those
// values by itself after each digest.
module sha1_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  logic               cmd_valid;
  logic               cmd_pop;
  sha1bsh_pkg::cmd_t  cmd;
  logic               out_space;
  logic               res_push;
  sha1bsh_pkg::res_t  res;
  sha1bsh_pkg::res_t  head;

  sha1bsh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  sha1bsh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_space (out_space),
    .res_push  (res_push),
    .res       (res)
  );

  sha1bsh_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .out_space (out_space),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign digest_word = head.word;
  assign word_number = head.num;
  assign last_word   = head.last;

endmodule
